@@ rtl/dtb_pkg.sv @@
// Package for the debounced trigger with back-off block.
// Holds widths, register indexes, function codes, phase type and helpers.
// No dependencies.
package dtb_pkg;

	localparam int TIME_WIDTH = 16;
	localparam int CFG_W      = 16;
	localparam int OUT_W      = 16;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [CFG_W-1:0]      cfg_t;

	localparam time_t TIME_MAX = {TIME_WIDTH{1'b1}};

	// Register indexes
	localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [1:0] REG_BACKOFF_MIN  = 2'd1;
	localparam logic [1:0] REG_BACKOFF_MAX  = 2'd2;
	localparam logic [1:0] REG_BACKOFF_INIT = 2'd3;

	// Reset values of the registers
	localparam cfg_t DEBOUNCE_RST     = CFG_W'(2000);
	localparam cfg_t BACKOFF_MIN_RST  = CFG_W'(500);
	localparam cfg_t BACKOFF_MAX_RST  = CFG_W'(30000);
	localparam cfg_t BACKOFF_INIT_RST = CFG_W'(500);
	localparam cfg_t DEBOUNCE_DEFAULT = CFG_W'(2000);

	// Item function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_EVENT = 2'd1;
	localparam logic [1:0] FUNC_DONE  = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_HOLDOFF  = 2'd2,
		PH_APPLY    = 2'd3
	} phase_t;

	// Reciprocal of 3 for values below 2**(TIME_WIDTH+1)
	localparam int DIV3_SHIFT = TIME_WIDTH + 1;
	localparam logic [DIV3_SHIFT-1:0] DIV3_MUL =
		DIV3_SHIFT'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

	// Clamp a register value to the counter range
	function automatic time_t sat_time(input cfg_t v);
		logic [CFG_W+TIME_WIDTH-1:0] ext;
		ext = (CFG_W+TIME_WIDTH)'(v);
		if (ext > (CFG_W+TIME_WIDTH)'(TIME_MAX))
			return TIME_MAX;
		else
			return TIME_WIDTH'(ext);
	endfunction

endpackage

@@ rtl/debounced_trigger_with_backoff_top.sv @@
// Debounced trigger with exponential back-off: top level.
// Latency: a result is valid the cycle after its input transfer.
// Throughput: one item per cycle; input ready stays high while the result
// register is empty or being taken in the same cycle.
// Reset (arst_n low, asynchronous): idle phase, counters zero, back-off at
// its initial value, registers at their defaults, no result held.
module debounced_trigger_with_backoff_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [dtb_pkg::CFG_W-1:0] cfg_wdata,
	// Item input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] apply_ok, [7:1] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	// Result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [0] apply_request, [2:1] phase,
	                                    // [18:3] backoff_ms, [23:19] zero
);
	import dtb_pkg::*;

	// Configuration registers; there is no init register: a write to the init index
	// loads the back-off directly, and the init reset value sets the back-off at reset
	cfg_t debounce_q, bo_min_q, bo_max_q;

	// Block state
	phase_t phase_q;
	time_t  quiet_q;
	time_t  holdoff_q;
	time_t  backoff_q;
	logic   pending_q;

	// Result register
	logic             out_valid_q;
	logic             out_req_q;
	phase_t           out_phase_q;
	logic [OUT_W-1:0] out_backoff_q;

	logic       accept;
	logic [1:0] func;
	logic       ok;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign func          = s_axis_tuser;
	assign ok            = s_axis_tdata[0];

	// Effective debounce time: zero means the default
	time_t eff_debounce;
	assign eff_debounce = sat_time((debounce_q == '0) ? DEBOUNCE_DEFAULT : debounce_q);

	time_t bo_lo, bo_hi, bo_next;
	assign bo_lo = sat_time(bo_min_q);
	assign bo_hi = sat_time(bo_max_q);

	dtb_backoff u_backoff (
		.cur  (backoff_q),
		.lo   (bo_lo),
		.hi   (bo_hi),
		.grow (!ok || pending_q),
		.nxt  (bo_next)
	);

	// Next-state logic for one item
	phase_t phase_d;
	time_t  quiet_d, holdoff_d, backoff_d, hold_dec, quiet_inc;
	logic   pending_d, req_d;

	assign hold_dec  = (holdoff_q != '0) ? holdoff_q - 1'b1 : holdoff_q;
	assign quiet_inc = (quiet_q < TIME_MAX) ? quiet_q + 1'b1 : quiet_q;

	always_comb begin
		phase_d   = phase_q;
		quiet_d   = quiet_q;
		holdoff_d = holdoff_q;
		backoff_d = backoff_q;
		pending_d = pending_q;
		req_d     = 1'b0;
		case (func)
			FUNC_TICK: begin
				holdoff_d = hold_dec;
				if (phase_q == PH_DEBOUNCE) begin
					quiet_d = quiet_inc;
					if (quiet_inc >= eff_debounce)
						phase_d = PH_HOLDOFF;
				end
				// Apply may start on the same tick the window closes
				if (phase_d == PH_HOLDOFF && hold_dec == '0) begin
					phase_d   = PH_APPLY;
					pending_d = 1'b0;
					req_d     = 1'b1;
				end
			end
			FUNC_EVENT: begin
				pending_d = 1'b1;
				if (phase_q == PH_IDLE || phase_q == PH_DEBOUNCE) begin
					phase_d = PH_DEBOUNCE;
					quiet_d = '0;
				end
			end
			FUNC_DONE: begin
				// Done outside an apply is dropped
				if (phase_q == PH_APPLY) begin
					backoff_d = bo_next;
					holdoff_d = bo_next;
					pending_d = 1'b0;
					phase_d   = PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			bo_min_q    <= BACKOFF_MIN_RST;
			bo_max_q    <= BACKOFF_MAX_RST;
			phase_q     <= PH_IDLE;
			quiet_q     <= '0;
			holdoff_q   <= '0;
			backoff_q   <= sat_time(BACKOFF_INIT_RST);
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Config writes are to arrive only while the block is idle; the block does not enforce this
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE:     debounce_q <= cfg_wdata;
					REG_BACKOFF_MIN:  bo_min_q   <= cfg_wdata;
					REG_BACKOFF_MAX:  bo_max_q   <= cfg_wdata;
					REG_BACKOFF_INIT: backoff_q  <= sat_time(cfg_wdata);
					default: ;
				endcase
			end
			if (accept) begin
				phase_q     <= phase_d;
				quiet_q     <= quiet_d;
				holdoff_q   <= holdoff_d;
				backoff_q   <= backoff_d;
				pending_q   <= pending_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload, loaded on each input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			out_req_q     <= req_d;
			out_phase_q   <= phase_d;
			out_backoff_q <= OUT_W'(backoff_d);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_backoff_q, out_phase_q, out_req_q};

endmodule

@@ rtl/dtb_backoff.sv @@
// Back-off update applied when an apply is reported done.
// Doubles with clamp to the maximum, or decays to 2/3 with floor at the minimum.
// Depends on dtb_pkg.
module dtb_backoff (
	input  dtb_pkg::time_t cur,
	input  dtb_pkg::time_t lo,
	input  dtb_pkg::time_t hi,
	input  logic           grow,
	output dtb_pkg::time_t nxt
);
	import dtb_pkg::*;

	logic [TIME_WIDTH:0]              dbl;
	logic [2*DIV3_SHIFT-1:0]          prod;
	time_t                            third2;

	assign dbl    = {cur, 1'b0};
	// 2*cur/3 by reciprocal multiply, exact over the doubled range
	assign prod   = (2*DIV3_SHIFT)'(dbl) * (2*DIV3_SHIFT)'(DIV3_MUL);
	assign third2 = TIME_WIDTH'(prod >> DIV3_SHIFT);

	always_comb begin
		nxt = cur;
		if (grow) begin
			if (dbl > (TIME_WIDTH+1)'(hi))
				nxt = hi;
			else
				nxt = TIME_WIDTH'(dbl);
		end else if (cur > lo) begin
			nxt = (third2 < lo) ? lo : third2;
		end
	end

endmodule
